/* rtl/tmf_pkg.sv */
// ----------------------------------------------------------------------------
// tmf_pkg
// shared types, register indexes and median helpers
// ----------------------------------------------------------------------------
package tmf_pkg;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd2;

   typedef logic [23:0] pixel_type;

   // three columns of (top, middle, bottom)
   typedef struct packed {
      pixel_type [2:0] l;
      pixel_type [2:0] m;
      pixel_type [2:0] r;
   } window_type;

   typedef struct packed {
      window_type win;
      logic       last;
      logic       done;
   } job_type;

   function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

/* rtl/tmf_front.sv */
// ----------------------------------------------------------------------------
// tmf_front
// accepts pixels, keeps line stores and window, issues up to four window jobs
// ----------------------------------------------------------------------------
module tmf_front
   import tmf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pixel_type              req_pixel,
   input  logic [11:0]            cfg_width,
   input  logic [15:0]            cfg_height,
   input  logic                   geom_restart,
   output logic                   job_valid,
   input  logic                   job_full,
   output job_type                job
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned CW = AW + 1;

   // stage a: memory read; stage b: window update and job issue
   pixel_type above_mem [MAX_WIDTH];
   pixel_type cur_mem   [MAX_WIDTH];

   logic [CW-1:0] eff_w;
   logic [15:0]   eff_h;
   always_comb begin
      if (cfg_width == 12'd0) eff_w = CW'(1);
      else if ({4'd0, cfg_width} > 16'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
      else eff_w = CW'(cfg_width);
      eff_h = (cfg_height == 16'd0) ? 16'd1 : cfg_height;
   end

   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;

   logic          b_valid_ff;
   pixel_type     b_px_ff;
   logic [CW-1:0] b_col_ff;
   logic [15:0]   b_row_ff;
   logic          b_lastcol_ff, b_lastrow_ff;
   pixel_type     rd_above_ff, rd_cur_ff;
   logic [2:0]    b_phase_ff, b_phase_in;
   window_type    win_ff, win_in;

   // first cycle of a held pixel: window and memory update happen once
   logic          upd_ff;

   // number of jobs issued for the held pixel
   logic [2:0] b_count;
   always_comb begin
      b_count = 3'd0;
      if (b_row_ff != 16'd0) b_count = b_count + 3'(b_col_ff != '0) + 3'(b_lastcol_ff);
      if (b_lastrow_ff) b_count = b_count + 3'(b_col_ff != '0) + 3'(b_lastcol_ff);
   end

   logic b_finish;
   assign b_finish = b_valid_ff && (b_phase_ff == b_count);

   logic b_free;
   assign b_free = !b_valid_ff || (b_finish && !job_valid) || (b_finish && !job_full);
   assign req_stall = !b_free;

   logic accept;
   assign accept = req_valid && !req_stall;

   logic [CW-1:0] a_col;
   logic [15:0]   a_row;
   assign a_col = (col_ff >= eff_w) ? '0 : col_ff;
   assign a_row = (row_ff >= eff_h) ? 16'd0 : row_ff;

   // forward when the held pixel writes the address being read
   logic fwd;
   assign fwd = upd_ff && (b_col_ff == a_col);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == eff_w - CW'(1)) begin
            col_in = '0;
            row_in = (row_ff == eff_h - 16'd1) ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (geom_restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_above_ff <= (fwd) ? rd_cur_ff : above_mem[a_col[AW-1:0]];
         rd_cur_ff   <= (fwd) ? b_px_ff : cur_mem[a_col[AW-1:0]];
         b_px_ff     <= req_pixel;
         b_col_ff    <= a_col;
         b_row_ff    <= a_row;
         b_lastcol_ff <= (a_col == eff_w - CW'(1));
         b_lastrow_ff <= (a_row == eff_h - 16'd1);
      end
      if (upd_ff) begin
         above_mem[b_col_ff[AW-1:0]] <= rd_cur_ff;
         cur_mem[b_col_ff[AW-1:0]]   <= b_px_ff;
      end
   end

   // new column from the held pixel
   pixel_type top, mid;
   always_comb begin
      if (b_row_ff == 16'd0) begin
         top = b_px_ff;
         mid = b_px_ff;
      end else if (b_row_ff == 16'd1) begin
         top = rd_cur_ff;
         mid = rd_cur_ff;
      end else begin
         top = rd_above_ff;
         mid = rd_cur_ff;
      end
   end

   window_type wcur;
   always_comb begin
      win_in = win_ff;
      if (upd_ff) begin
         if (b_col_ff == '0) begin
            win_in.l = {b_px_ff, mid, top};
            win_in.m = {b_px_ff, mid, top};
            win_in.r = {b_px_ff, mid, top};
         end else begin
            win_in.l = win_ff.m;
            win_in.m = win_ff.r;
            win_in.r = {b_px_ff, mid, top};
         end
      end
      wcur = win_in;
   end

   // job sequencing: list of up to four kinds in order
   logic [1:0] kind;
   logic       any_job;
   always_comb begin
      logic [2:0] k;
      logic [1:0] list [4];
      logic [2:0] n;
      n = 3'd0;
      for (k = 3'd0; k < 3'd4; k = k + 3'd1) list[k[1:0]] = 2'd0;
      if (b_row_ff != 16'd0 && b_col_ff != '0) begin list[n[1:0]] = 2'd0; n = n + 3'd1; end
      if (b_row_ff != 16'd0 && b_lastcol_ff) begin list[n[1:0]] = 2'd1; n = n + 3'd1; end
      if (b_lastrow_ff && b_col_ff != '0) begin list[n[1:0]] = 2'd2; n = n + 3'd1; end
      if (b_lastrow_ff && b_lastcol_ff) begin list[n[1:0]] = 2'd3; n = n + 3'd1; end
      kind = list[b_phase_ff[1:0]];
      any_job = b_valid_ff && (b_phase_ff < b_count);
   end

   always_comb begin
      job.last = (b_phase_ff + 3'd1 == b_count);
      job.done = (kind == 2'd3);
      unique case (kind)
         2'd0: job.win = wcur;
         2'd1: begin
            job.win.l = wcur.m;
            job.win.m = wcur.r;
            job.win.r = wcur.r;
         end
         2'd2: begin
            job.win.l = {wcur.l[2], wcur.l[2], wcur.l[1]};
            job.win.m = {wcur.m[2], wcur.m[2], wcur.m[1]};
            job.win.r = {wcur.r[2], wcur.r[2], wcur.r[1]};
         end
         default: begin
            job.win.l = {wcur.m[2], wcur.m[2], wcur.m[1]};
            job.win.m = {wcur.r[2], wcur.r[2], wcur.r[1]};
            job.win.r = {wcur.r[2], wcur.r[2], wcur.r[1]};
         end
      endcase
   end

   assign job_valid = any_job;

   always_comb begin
      b_phase_in = b_phase_ff;
      if (b_valid_ff && b_phase_ff < b_count && !job_full) b_phase_in = b_phase_ff + 3'd1;
      else if (b_valid_ff && b_phase_ff == 3'd0) b_phase_in = 3'd0;
      if (accept) b_phase_in = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         b_phase_ff <= 3'd0;
         win_ff     <= '0;
         upd_ff     <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) b_valid_ff <= 1'b1;
         else if (b_finish) b_valid_ff <= 1'b0;
         b_phase_ff <= b_phase_in;
         if (upd_ff) win_ff <= win_in;
         upd_ff <= accept;
      end
   end

endmodule

/* rtl/tmf_queue.sv */
// ----------------------------------------------------------------------------
// tmf_queue
// short fifo of window jobs between front and back
// ----------------------------------------------------------------------------
module tmf_queue
   import tmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    full,
   input  job_type wr_job,
   output logic    rd_valid,
   input  logic    rd_take,
   output job_type rd_job
);

   job_type    slot_ff [4];
   logic [2:0] cnt_ff;
   logic [1:0] wp_ff, rp_ff;

   logic wr, rd;
   assign full = (cnt_ff == 3'd4);
   assign wr = wr_valid && !full;
   assign rd = rd_take && rd_valid;
   assign rd_valid = (cnt_ff != 3'd0);
   assign rd_job = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr) slot_ff[wp_ff] <= wr_job;
      if (reset) begin
         cnt_ff <= 3'd0;
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr) - 3'(rd);
      end
   end

endmodule

/* rtl/tmf_back.sv */
// ----------------------------------------------------------------------------
// tmf_back
// median network, threshold select and output register
// ----------------------------------------------------------------------------
module tmf_back
   import tmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_take,
   input  job_type    job,
   input  logic [7:0] threshold,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output pixel_type  rsp_pixel,
   output logic       rsp_last,
   output logic       rsp_done
);

   // stage 1: row min/med/max; stage 2: final median and select
   logic      s1_valid_ff;
   logic [7:0] s1_lo_ff [3], s1_md_ff [3], s1_hi_ff [3], s1_ctr_ff [3];
   logic      s1_last_ff, s1_done_ff;

   logic s2_free, s1_free;
   assign s2_free = !rsp_valid || !rsp_stall;
   assign s1_free = !s1_valid_ff || s2_free;
   assign job_take = job_valid && s1_free;

   always_ff @(posedge clock) begin
      if (job_take) begin
         for (int ch = 0; ch < 3; ch++) begin
            logic [7:0] mn [3], md [3], mx [3];
            for (int k = 0; k < 3; k++) begin
               logic [7:0] a, b, c;
               a = job.win.l[k][8*ch +: 8];
               b = job.win.m[k][8*ch +: 8];
               c = job.win.r[k][8*ch +: 8];
               mn[k] = min2(a, min2(b, c));
               md[k] = med3(a, b, c);
               mx[k] = max2(a, max2(b, c));
            end
            s1_lo_ff[ch]  <= max2(mn[0], max2(mn[1], mn[2]));
            s1_md_ff[ch]  <= med3(md[0], md[1], md[2]);
            s1_hi_ff[ch]  <= min2(mx[0], min2(mx[1], mx[2]));
            s1_ctr_ff[ch] <= job.win.m[1][8*ch +: 8];
         end
         s1_last_ff <= job.last;
         s1_done_ff <= job.done;
      end
      if (s1_valid_ff && s2_free) begin
         for (int ch = 0; ch < 3; ch++) begin
            logic [7:0] m, d;
            m = med3(s1_lo_ff[ch], s1_md_ff[ch], s1_hi_ff[ch]);
            d = (m > s1_ctr_ff[ch]) ? m - s1_ctr_ff[ch] : s1_ctr_ff[ch] - m;
            rsp_pixel[8*ch +: 8] <= (d > threshold) ? m : s1_ctr_ff[ch];
         end
         rsp_last <= s1_last_ff;
         rsp_done <= s1_done_ff;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= job_take;
         if (s2_free) rsp_valid <= s1_valid_ff;
      end
   end

endmodule

/* rtl/thresholded_median_3x3.sv */
// ----------------------------------------------------------------------------
// thresholded_median_3x3
// thresholded 3x3 rgb median filter over a raster pixel stream
// ----------------------------------------------------------------------------
// path: a result passes the front's issue stage, the job queue and two median stages
// pacing: the front holds a pixel until its last job is queued, then takes the next one;
//   stalls from the job queue and from the result port can hold it there
// reset: counters, window and handshakes clear; line stores are not cleared
// ----------------------------------------------------------------------------
module thresholded_median_3x3
   import tmf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0]  thr_ff;
   logic [11:0] width_ff;
   logic [15:0] height_ff;
   logic        csr_wr, restart;

   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid && csr_ready;
   assign restart = csr_wr && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= 8'd0;
         width_ff  <= 12'd2048;
         height_ff <= 16'd1;
      end else if (csr_wr) begin
         if (csr_index == CSR_THRESHOLD) thr_ff <= csr_data[7:0];
         if (csr_index == CSR_WIDTH) width_ff <= csr_data[11:0];
         if (csr_index == CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   logic    f_valid, q_full, q_valid, q_take;
   job_type f_job, q_job;
   pixel_type out_px;

   tmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel({req_blue_in, req_green_in, req_red_in}),
      .cfg_width(width_ff), .cfg_height(height_ff), .geom_restart(restart),
      .job_valid(f_valid), .job_full(q_full), .job(f_job)
   );

   tmf_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(f_valid), .full(q_full), .wr_job(f_job),
      .rd_valid(q_valid), .rd_take(q_take), .rd_job(q_job)
   );

   tmf_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_take(q_take), .job(q_job), .threshold(thr_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pixel(out_px),
      .rsp_last(rsp_last_of_run), .rsp_done(rsp_frame_done)
   );

   assign rsp_red_out   = out_px[7:0];
   assign rsp_green_out = out_px[15:8];
   assign rsp_blue_out  = out_px[23:16];

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_run)
      else $error("frame_done without last_of_run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(out_px))
      else $error("stalled result changed");

   a_queue_ok: assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_valid)
      else $error("full queue reports empty");

endmodule
